FILE: design/rtrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtrd_pkg
// Shared types and codes for the run-length texel decoder.
// ----------------------------------------------------------------------------
package rtrd_pkg;

    localparam int CB_W = 18;   // compressed size register width

    // decoder phase
    localparam logic [1:0] PH_CODE = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_REP  = 2'd2;

    // end status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ODD       = 3'd1;
    localparam logic [2:0] ST_LIT_PAST  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    typedef struct packed {
        logic [13:0] run_start;
        logic [15:0] run_length;
        logic [15:0] texel_value;
        logic [2:0]  status;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

FILE: design/rtrd_decode_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtrd_decode_core
// Decoder state and the per-word step: consumes one coded word per enabled
// cycle until decoding ends and produces at most one run record.
// ----------------------------------------------------------------------------
module rtrd_decode_core
    import rtrd_pkg::*;
#(
    parameter int TEX_WIDTH  = 128,
    parameter int TEX_HEIGHT = 128
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [CB_W-1:0] cfg_bytes,
    input  wire logic            step_en,
    input  wire logic [15:0]     word,
    output logic                 res_valid,
    output result_t              res
);

    localparam int TEXEL_TOTAL = TEX_WIDTH * TEX_HEIGHT;
    localparam int POS_W       = $clog2(TEXEL_TOTAL + 1);
    localparam int SUM_W       = ((POS_W > 16) ? POS_W : 16) + 1;
    localparam logic [SUM_W-1:0] TOTAL_S = SUM_W'(TEXEL_TOTAL);

    logic [CB_W-1:0]  cb_reg;
    logic [1:0]       phase_reg, phase_next;
    logic [15:0]      lit_left_reg, lit_left_next;
    logic [14:0]      rep_cnt_reg, rep_cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CB_W-1:0]  used_reg, used_next;
    logic             halted_reg, halted_next;
    logic [2:0]       end_st_reg, end_st_next;

    logic [CB_W:0]    used_p2;
    logic [CB_W+1:0]  lit_end, rep_end;
    logic [15:0]      sub;
    logic [SUM_W-1:0] lit_pos_end, rep_pos_end;
    logic [31:0]      pos_wide, pos_next_wide;
    logic             ended;

    assign used_p2     = {1'b0, used_reg} + (CB_W+1)'(2);
    assign sub         = 16'(17'h10000 - {1'b0, word});
    assign lit_end     = {1'b0, used_p2} + (CB_W+2)'({sub, 1'b0});
    assign rep_end     = {1'b0, used_p2} + (CB_W+2)'(2);
    assign lit_pos_end = SUM_W'(pos_reg) + SUM_W'(sub);
    assign rep_pos_end = SUM_W'(pos_reg) + SUM_W'(word[14:0]);
    assign pos_wide      = 32'(pos_reg);
    assign pos_next_wide = 32'(pos_next);

    always_comb
    begin
        phase_next    = phase_reg;
        lit_left_next = lit_left_reg;
        rep_cnt_next  = rep_cnt_reg;
        pos_next      = pos_reg;
        used_next     = used_reg;
        halted_next   = halted_reg;
        end_st_next   = end_st_reg;
        res_valid     = 1'b0;
        ended         = 1'b0;
        res.run_start   = pos_wide[13:0];
        res.run_length  = '0;
        res.texel_value = '0;
        res.status      = ST_OK;
        res.last        = 1'b1;

        if (halted_reg) begin
            res_valid  = 1'b1;
            res.status = end_st_reg;
        end else if (cb_reg[0]) begin
            res_valid   = 1'b1;
            halted_next = 1'b1;
            end_st_next = ST_ODD;
            res.status  = ST_ODD;
        end else if (used_reg >= cb_reg) begin
            res_valid   = 1'b1;
            halted_next = 1'b1;
            end_st_next = ST_OK;
        end else begin
            used_next = used_p2[CB_W-1:0];
            unique case (phase_reg)
                PH_LIT:
                begin
                    res_valid       = 1'b1;
                    res.run_length  = 16'd1;
                    res.texel_value = word;
                    pos_next        = pos_reg + POS_W'(1);
                    lit_left_next   = lit_left_reg - 16'd1;
                    if (lit_left_reg == 16'd1)
                        phase_next = PH_CODE;
                end
                PH_REP:
                begin
                    res_valid       = 1'b1;
                    res.run_length  = 16'(rep_cnt_reg);
                    res.texel_value = word;
                    pos_next        = pos_reg + POS_W'(rep_cnt_reg);
                    rep_cnt_next    = '0;
                    phase_next      = PH_CODE;
                end
                PH_CODE:
                begin
                    if (word[15]) begin
                        if ({2'b0, cb_reg} < lit_end) begin
                            ended      = 1'b1;
                            res.status = ST_LIT_PAST;
                        end else if (lit_pos_end > TOTAL_S) begin
                            ended      = 1'b1;
                            res.status = ST_OVERFLOW;
                        end else begin
                            lit_left_next = sub;
                            phase_next    = PH_LIT;
                        end
                    end else if (word != 16'd0) begin
                        if ({2'b0, cb_reg} < rep_end) begin
                            ended      = 1'b1;
                            res.status = ST_TRUNC;
                        end else if (rep_pos_end > TOTAL_S) begin
                            ended      = 1'b1;
                            res.status = ST_OVERFLOW;
                        end else begin
                            rep_cnt_next = word[14:0];
                            phase_next   = PH_REP;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_CODE;
                end
            endcase

            if (ended) begin
                // error: status-only record, run counters as they were
                res_valid     = 1'b1;
                halted_next   = 1'b1;
                end_st_next   = res.status;
                phase_next    = phase_reg;
                lit_left_next = lit_left_reg;
                rep_cnt_next  = rep_cnt_reg;
                pos_next      = pos_reg;
            end else if (used_p2 >= {1'b0, cb_reg}) begin
                halted_next = 1'b1;
                end_st_next = ST_OK;
                if (!res_valid) begin
                    res_valid     = 1'b1;
                    res.run_start = pos_next_wide[13:0];
                end
            end else begin
                res.last = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cb_reg       <= '0;
            phase_reg    <= PH_CODE;
            lit_left_reg <= '0;
            rep_cnt_reg  <= '0;
            pos_reg      <= '0;
            used_reg     <= '0;
            halted_reg   <= 1'b0;
            end_st_reg   <= ST_OK;
        end else if (cfg_we) begin
            cb_reg       <= cfg_bytes;
            phase_reg    <= PH_CODE;
            lit_left_reg <= '0;
            rep_cnt_reg  <= '0;
            pos_reg      <= '0;
            used_reg     <= '0;
            halted_reg   <= 1'b0;
            end_st_reg   <= ST_OK;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            rep_cnt_reg  <= rep_cnt_next;
            pos_reg      <= pos_next;
            used_reg     <= used_next;
            halted_reg   <= halted_next;
            end_st_reg   <= end_st_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/rle_texel_run_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rle_texel_run_decoder
// Run-length texel stream decoder, one coded word per request.
// ----------------------------------------------------------------------------
// Takes one 16-bit coded word per cycle while the output is not stalled and
// returns run records (start, length, value) with a status and a last flag.
// A word is registered on acceptance and decoded against the run state once
// the output register is empty or being read, and its record is loaded into
// the output register at the end of that cycle. The rate is set by the
// update of the run counters and byte count in the decode cycle. Writing
// compressed_bytes restarts decoding; write it only while no request is in flight.
module rle_texel_run_decoder
    import rtrd_pkg::*;
#(
    parameter int TEX_WIDTH  = 128,
    parameter int TEX_HEIGHT = 128
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            compressed_bytes_wr,
    input  wire logic [CB_W-1:0] compressed_bytes,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [15:0]     code_word,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [13:0]          run_start,
    output logic [15:0]          run_length,
    output logic [15:0]          texel_value,
    output logic [2:0]           status,
    output logic                 last
);

    logic        in_valid_reg;
    logic [15:0] in_word_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg;
    logic        advance;
    logic        res_valid;
    result_t     res;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    rtrd_decode_core #(
        .TEX_WIDTH  (TEX_WIDTH),
        .TEX_HEIGHT (TEX_HEIGHT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (compressed_bytes_wr),
        .cfg_bytes (compressed_bytes),
        .step_en   (advance),
        .word      (in_word_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid_next = advance ? res_valid : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_word_reg <= code_word;
        if (advance)
            out_data_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign run_start   = out_data_reg.run_start;
    assign run_length  = out_data_reg.run_length;
    assign texel_value = out_data_reg.texel_value;
    assign status      = out_data_reg.status;
    assign last        = out_data_reg.last;

endmodule
`default_nettype wire

FILE: design/rtrd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtrd_checker
// Port-level checks for the run-length texel decoder.
// ----------------------------------------------------------------------------
module rtrd_checker
    import rtrd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        compressed_bytes_wr,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [13:0] run_start,
    input wire logic [15:0] run_length,
    input wire logic [15:0] texel_value,
    input wire logic [2:0]  status,
    input wire logic        last
);

    logic ended_reg;

    // set once a last record is taken, cleared by a restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ended_reg <= 1'b0;
        else if (compressed_bytes_wr)
            ended_reg <= 1'b0;
        else if (out_valid && out_ready && last)
            ended_reg <= 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_start)
            && $stable(run_length) && $stable(texel_value) && $stable(status)
            && $stable(last))
        else $error("result changed while stalled");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_length == 16'd0 |-> last && texel_value == 16'd0)
        else $error("status-only record without last");

    a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && run_length == 16'd0)
        else $error("error status on a run record");

    a_sticky_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ended_reg && !compressed_bytes_wr |-> last && run_length == 16'd0)
        else $error("record after end of decoding");

endmodule

bind rle_texel_run_decoder rtrd_checker u_rtrd_checker (.*);
`default_nettype wire
